// ===== rtl/nfa_pkg.sv =====
// Package: NFA step types, sizes and codes.
package nfa_pkg;

	localparam int NUM_STATES  = 16;
	localparam int NUM_SYMBOLS = 16;
	localparam int STATE_W     = $clog2(NUM_STATES);
	localparam int SYM_W       = $clog2(NUM_SYMBOLS);
	localparam int SET_W       = NUM_STATES;
	localparam int ADDR_W      = STATE_W + SYM_W;
	localparam int DEPTH       = NUM_STATES * NUM_SYMBOLS;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_START = 2'd1,
		KIND_APPLY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_DRAIN
	} seq_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  state_index;
		logic [3:0]  symbol;
		logic [15:0] target_mask;
	} req_t;

	typedef struct packed {
		logic [3:0]  applied_symbol;
		logic        is_start;
		logic [15:0] active_set;
		logic        set_empty;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [SET_W-1:0]  data;
	} store_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} store_rd_t;

endpackage

// ===== rtl/nfa_state_set_step.sv =====
// Top level: NFA active-set stepper with a sequenced scan of the transition store.
//
//  channel  | handshake      | payload         | notes
//  request  | start / busy   | req  (req_t)    | taken when start && !busy
//  result   | done           | result (res_t)  | one-cycle strobe, no back-pressure
//
// Load: written in the accept cycle, no result, busy stays low.
// Start: result in the cycle after accept, busy stays low.
// Apply: the single read port of the store is read once per state (16 reads),
// through a registered read, then the drain state loads the result register.
// Reset clears the active set and every store entry (valid bits) at once.
// The result cannot be stalled; it is shown for one cycle only.
module nfa_state_set_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  nfa_pkg::req_t req,
	output logic          done,
	output nfa_pkg::res_t result
);
	import nfa_pkg::*;

	seq_state_t         state_q, state_d;
	logic [STATE_W-1:0] cnt_q;
	logic [SYM_W-1:0]   sym_q;
	logic [SET_W-1:0]   cur_set_q;
	logic [SET_W-1:0]   acc_q;
	logic [SET_W-1:0]   acc_d;
	logic               sel_s1;
	logic               vld_s1;
	logic               done_q;
	res_t               res_q;
	logic               accept;
	store_wr_t          wr;
	store_rd_t          rd;
	logic [SET_W-1:0]   rd_data;

	assign accept = start && !busy;

	assign wr.en   = accept && (req.kind == KIND_LOAD);
	assign wr.addr = {req.state_index[STATE_W-1:0], req.symbol[SYM_W-1:0]};
	assign wr.data = req.target_mask[SET_W-1:0];

	assign rd.en   = (state_q == SEQ_SCAN);
	assign rd.addr = {cnt_q, sym_q};

	nfa_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	assign acc_d = acc_q | ((vld_s1 && sel_s1) ? rd_data : '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (accept && (req.kind == KIND_APPLY)) state_d = SEQ_SCAN;
			end
			SEQ_SCAN: begin
				if (cnt_q == STATE_W'(NUM_STATES - 1)) state_d = SEQ_DRAIN;
			end
			SEQ_DRAIN: state_d = SEQ_IDLE;
			default:   state_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SEQ_IDLE;
			cnt_q     <= '0;
			cur_set_q <= '0;
			vld_s1    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd.en;
			done_q  <= 1'b0;
			if (state_q == SEQ_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (accept && (req.kind == KIND_START)) begin
				cur_set_q <= SET_W'(1) << req.state_index[STATE_W-1:0];
				done_q    <= 1'b1;
			end
			if (state_q == SEQ_DRAIN) begin
				cur_set_q <= acc_d;
				done_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		sel_s1 <= cur_set_q[cnt_q];
		if (accept) begin
			sym_q <= req.symbol[SYM_W-1:0];
			acc_q <= '0;
		end else if (state_q != SEQ_IDLE) begin
			acc_q <= acc_d;
		end
		if (accept && (req.kind == KIND_START)) begin
			res_q.applied_symbol <= '0;
			res_q.is_start       <= 1'b1;
			res_q.active_set     <= 16'(SET_W'(1) << req.state_index[STATE_W-1:0]);
			res_q.set_empty      <= 1'b0;
		end else if (state_q == SEQ_DRAIN) begin
			res_q.applied_symbol <= 4'(sym_q);
			res_q.is_start       <= 1'b0;
			res_q.active_set     <= 16'(acc_d);
			res_q.set_empty      <= (acc_d == '0);
		end
	end

	assign busy   = (state_q != SEQ_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_start_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == KIND_START) |=> (done && result.is_start))
		else $error("start request gave no start result");

	a_apply_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == KIND_APPLY) |=> busy)
		else $error("apply request did not start the scan");

	a_apply_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.is_start) |-> $past(state_q == SEQ_DRAIN))
		else $error("apply result without a finished scan");

endmodule

// ===== rtl/nfa_store.sv =====
// Transition mask store: one write port, one registered read port, per-entry valid bits.
module nfa_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  nfa_pkg::store_wr_t       wr,
	input  nfa_pkg::store_rd_t       rd,
	output logic [nfa_pkg::SET_W-1:0] rd_data
);
	import nfa_pkg::*;

	logic [SET_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [SET_W-1:0] rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rvld_q <= vld_q[rd.addr];
			end
		end
	end

	// never-loaded pairs read as an empty mask
	assign rd_data = rvld_q ? rdata_q : '0;

endmodule
